@@ sv/msps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants of the multiplexed servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int NUM_PINS         = 4;
  localparam int POS_W            = 8;
  localparam int TIME_W           = 16;
  localparam int CHAN_W           = 2;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;

  localparam logic [TIME_W-1:0] MIN_PULSE_RST   = 16'd100;
  localparam logic [TIME_W-1:0] SLOT_LENGTH_RST = 16'd2000;

  // Item commands.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_MIN_PULSE   = 1'b0;
  localparam logic REG_SLOT_LENGTH = 1'b1;

  typedef struct packed {
    logic                           command;
    logic [NUM_PINS-1:0][POS_W-1:0] position;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] min_pulse;
    logic [TIME_W-1:0] slot_length;
  } cfg_t;

  typedef struct packed {
    logic [NUM_PINS-1:0] pin_levels;
    logic [CHAN_W-1:0]   slot_channel;
    logic                slot_end;
  } result_t;

endpackage

@@ sv/msps_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_seq
// Slot sequencer: holds the phase, channel, counters, positions and pins,
// and advances them by one item whenever step is high.
// ----------------------------------------------------------------------------
module msps_seq #(
  parameter int NUM_CHANNELS = msps_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  msps_pkg::item_t   item,
  input  msps_pkg::cfg_t    cfg,
  output msps_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ON     = 2'd1,
    PH_OFF    = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  localparam logic [msps_pkg::CHAN_W-1:0] LAST_CHAN =
    msps_pkg::CHAN_W'(NUM_CHANNELS - 1);

  phase_t                                                   phase, phase_next;
  logic [msps_pkg::CHAN_W-1:0]                              channel, channel_next;
  logic [msps_pkg::TIME_W-1:0]                              on_count, on_count_next;
  logic [msps_pkg::TIME_W-1:0]                              off_count, off_count_next;
  logic [msps_pkg::NUM_PINS-1:0][msps_pkg::POS_W-1:0]       active, active_next;
  logic [msps_pkg::NUM_PINS-1:0][msps_pkg::POS_W-1:0]       pending, pending_next;
  logic [msps_pkg::NUM_PINS-1:0]                            pins, pins_next;
  logic                                                     slot_end;

  logic [msps_pkg::TIME_W:0]   on_sum;
  logic [msps_pkg::TIME_W-1:0] on_time;

  // On time of the current channel, capped at the slot length.
  assign on_sum  = {1'b0, cfg.min_pulse} +
                   {{(msps_pkg::TIME_W + 1 - msps_pkg::POS_W){1'b0}}, active[channel]};
  assign on_time = (on_sum > {1'b0, cfg.slot_length}) ? cfg.slot_length
                                                      : on_sum[msps_pkg::TIME_W-1:0];

  always_comb begin
    phase_next     = phase;
    channel_next   = channel;
    on_count_next  = on_count;
    off_count_next = off_count;
    active_next    = active;
    pending_next   = pending;
    pins_next      = pins;
    slot_end       = 1'b0;
    if (item.command == msps_pkg::CMD_LOAD) begin
      pending_next = item.position;
    end else begin
      unique case (phase)
        PH_START: begin
          pins_next[channel] = 1'b1;
          on_count_next      = on_time;
          off_count_next     = cfg.slot_length - on_time;
          phase_next         = PH_ON;
        end
        PH_ON: begin
          if (on_count <= msps_pkg::TIME_W'(1)) begin
            on_count_next      = '0;
            pins_next[channel] = 1'b0;
            phase_next         = PH_OFF;
          end else begin
            on_count_next = on_count - msps_pkg::TIME_W'(1);
          end
        end
        PH_OFF: begin
          if (off_count <= msps_pkg::TIME_W'(1)) begin
            off_count_next = '0;
            phase_next     = PH_START;
            channel_next   = (channel == LAST_CHAN) ? '0
                                                    : channel + msps_pkg::CHAN_W'(1);
            active_next    = pending;
            slot_end       = 1'b1;
          end else begin
            off_count_next = off_count - msps_pkg::TIME_W'(1);
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  assign result.pin_levels   = pins_next;
  assign result.slot_channel = channel_next;
  assign result.slot_end     = slot_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      channel   <= '0;
      on_count  <= '0;
      off_count <= '0;
      active    <= '0;
      pending   <= '0;
      pins      <= '0;
    end else if (step) begin
      phase     <= phase_next;
      channel   <= channel_next;
      on_count  <= on_count_next;
      off_count <= off_count_next;
      active    <= active_next;
      pending   <= pending_next;
      pins      <= pins_next;
    end
  end

endmodule

@@ sv/multiplexed_servo_pulse_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_sequencer_core
// Time-slotted servo pulse sequencer with an input register, a one-pass
// step stage and a two-entry result buffer.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_stall    command, position_a .. position_d
//  result   out_valid / out_stall  pin_levels, slot_channel, slot_end
//  config   APB psel / penable     paddr, pwdata, prdata (min_pulse, slot_length)
//
// One item per cycle while in_stall is low; a result is offered once its item
// has passed the input register and the step logic into the result register.
// The result register plus a skid register let the input keep flowing after
// out_stall rises; in_stall rises once the skid and the input register are full.
// Synchronous reset clears the sequencer state, positions and both buffers,
// and sets min_pulse to 100 and slot_length to 2000.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer_core #(
  parameter int NUM_CHANNELS = msps_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [msps_pkg::POS_W-1:0]    position_a,
  input  logic [msps_pkg::POS_W-1:0]    position_b,
  input  logic [msps_pkg::POS_W-1:0]    position_c,
  input  logic [msps_pkg::POS_W-1:0]    position_d,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msps_pkg::NUM_PINS-1:0] pin_levels,
  output logic [msps_pkg::CHAN_W-1:0]   slot_channel,
  output logic                          slot_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msps_pkg::ADDR_W-1:0]   paddr,
  input  logic [msps_pkg::DATA_W-1:0]   pwdata,
  output logic [msps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  msps_pkg::cfg_t    cfg;
  msps_pkg::item_t   in_item;
  msps_pkg::item_t   s1_item;
  msps_pkg::result_t step_result;
  msps_pkg::result_t skid;
  logic              s1_valid;
  logic              skid_valid;
  logic              in_take;
  logic              s1_adv;
  logic              out_free;
  logic              cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse   <= msps_pkg::MIN_PULSE_RST;
      cfg.slot_length <= msps_pkg::SLOT_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        msps_pkg::REG_MIN_PULSE:   cfg.min_pulse   <= pwdata[msps_pkg::TIME_W-1:0];
        msps_pkg::REG_SLOT_LENGTH: cfg.slot_length <= pwdata[msps_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      msps_pkg::REG_MIN_PULSE:
        prdata = msps_pkg::DATA_W'(cfg.min_pulse);
      msps_pkg::REG_SLOT_LENGTH:
        prdata = msps_pkg::DATA_W'(cfg.slot_length);
      default:
        prdata = '0;
    endcase
  end

  // Input register.
  assign in_item.command     = command;
  assign in_item.position[0] = position_a;
  assign in_item.position[1] = position_b;
  assign in_item.position[2] = position_c;
  assign in_item.position[3] = position_d;

  assign in_stall = s1_valid && skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign s1_adv   = s1_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_item;
    end
  end

  msps_seq #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .item   (s1_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s1_adv;
      end
    end else if (s1_adv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        {pin_levels, slot_channel, slot_end} <= skid;
      end else if (s1_adv) begin
        {pin_levels, slot_channel, slot_end} <= step_result;
      end
    end else if (s1_adv) begin
      skid <= step_result;
    end
  end

  // The skid entry is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the result register is empty");

  // At most the current channel's pin is high.
  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(pin_levels))
    else $error("more than one servo pin high");

  // A slot ends only after its pin has gone low.
  a_slot_end_pins_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slot_end) |-> (pin_levels == '0))
    else $error("slot ended with a pin still high");

endmodule

@@ bench/msps_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msps_result_checker
// Follows the item, result and register channels of the servo sequencer,
// keeps its own copy of the slot state and compares every result it sees.
// ----------------------------------------------------------------------------
module msps_result_checker #(
  parameter int NUM_CHANNELS = msps_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          command,
  input  logic [msps_pkg::POS_W-1:0]    position_a,
  input  logic [msps_pkg::POS_W-1:0]    position_b,
  input  logic [msps_pkg::POS_W-1:0]    position_c,
  input  logic [msps_pkg::POS_W-1:0]    position_d,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [msps_pkg::NUM_PINS-1:0] pin_levels,
  input  logic [msps_pkg::CHAN_W-1:0]   slot_channel,
  input  logic                          slot_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [msps_pkg::ADDR_W-1:0]   paddr,
  input  logic [msps_pkg::DATA_W-1:0]   pwdata,
  output int                            pending,
  output int                            failures
);

  localparam int PRINT_CAP = 60;

  typedef enum logic [1:0] {SLOT_START, PULSE_HIGH, PULSE_REST} slot_phase_t;

  slot_phase_t                   phase_q;
  logic [msps_pkg::CHAN_W-1:0]   channel_q;
  logic [16:0]                   on_left;
  logic [16:0]                   off_left;
  logic [msps_pkg::POS_W-1:0]    active_pos  [msps_pkg::NUM_PINS];
  logic [msps_pkg::POS_W-1:0]    pending_pos [msps_pkg::NUM_PINS];
  logic [msps_pkg::NUM_PINS-1:0] pins_q;
  logic [msps_pkg::TIME_W-1:0]   min_pulse_q;
  logic [msps_pkg::TIME_W-1:0]   slot_length_q;
  msps_pkg::result_t             expected_results [$];

  initial failures = 0;
  initial pending = 0;

  task automatic report_failure(input string msg);
    if (failures < PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
    failures++;
  endtask

  // Advances the slot state by one item and returns the pin picture after it.
  function automatic msps_pkg::result_t step_sequencer(input msps_pkg::item_t it);
    msps_pkg::result_t r;
    logic [16:0]       on_time;
    r.slot_end = 1'b0;
    if (it.command == msps_pkg::CMD_LOAD) begin
      for (int i = 0; i < msps_pkg::NUM_PINS; i++) pending_pos[i] = it.position[i];
    end else begin
      case (phase_q)
        SLOT_START: begin
          pins_q[channel_q] = 1'b1;
          on_time = {1'b0, min_pulse_q} + {9'b0, active_pos[channel_q]};
          if (on_time > {1'b0, slot_length_q}) on_time = {1'b0, slot_length_q};
          on_left  = on_time;
          off_left = {1'b0, slot_length_q} - on_time;
          phase_q  = PULSE_HIGH;
        end
        PULSE_HIGH: begin
          // A zero on time still leaves the pin high for the start tick.
          if (on_left <= 17'd1) begin
            on_left           = '0;
            pins_q[channel_q] = 1'b0;
            phase_q           = PULSE_REST;
          end else begin
            on_left = on_left - 17'd1;
          end
        end
        PULSE_REST: begin
          if (off_left <= 17'd1) begin
            off_left  = '0;
            phase_q   = SLOT_START;
            channel_q = msps_pkg::CHAN_W'((int'(channel_q) + 1) % NUM_CHANNELS);
            for (int i = 0; i < msps_pkg::NUM_PINS; i++) active_pos[i] = pending_pos[i];
            r.slot_end = 1'b1;
          end else begin
            off_left = off_left - 17'd1;
          end
        end
        default: begin
          phase_q = SLOT_START;
        end
      endcase
    end
    r.pin_levels   = pins_q;
    r.slot_channel = channel_q;
    return r;
  endfunction

  always @(posedge clk) begin
    msps_pkg::item_t   taken;
    msps_pkg::result_t seen;
    msps_pkg::result_t want;
    if (rst) begin
      phase_q       = SLOT_START;
      channel_q     = '0;
      on_left       = '0;
      off_left      = '0;
      pins_q        = '0;
      min_pulse_q   = msps_pkg::MIN_PULSE_RST;
      slot_length_q = msps_pkg::SLOT_LENGTH_RST;
      for (int i = 0; i < msps_pkg::NUM_PINS; i++) begin
        active_pos[i]  = '0;
        pending_pos[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[msps_pkg::ADDR_W-1] == msps_pkg::REG_MIN_PULSE) begin
          min_pulse_q = pwdata[msps_pkg::TIME_W-1:0];
        end else begin
          slot_length_q = pwdata[msps_pkg::TIME_W-1:0];
        end
      end
      // Results are compared before the new item is predicted, since a result
      // can never belong to the item taken at the same edge.
      if (out_valid && !out_stall) begin
        seen.pin_levels   = pin_levels;
        seen.slot_channel = slot_channel;
        seen.slot_end     = slot_end;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result %b/%0d/%b arrived with none expected",
                                   seen.pin_levels, seen.slot_channel, seen.slot_end));
        end else begin
          want = expected_results.pop_front();
          if (seen.pin_levels !== want.pin_levels) begin
            report_failure($sformatf("pin_levels expected %b, got %b",
                                     want.pin_levels, seen.pin_levels));
          end
          if (seen.slot_channel !== want.slot_channel) begin
            report_failure($sformatf("slot_channel expected %0d, got %0d",
                                     want.slot_channel, seen.slot_channel));
          end
          if (seen.slot_end !== want.slot_end) begin
            report_failure($sformatf("slot_end expected %b, got %b",
                                     want.slot_end, seen.slot_end));
          end
        end
      end
      if (in_valid && !in_stall) begin
        taken.command     = command;
        taken.position[0] = position_a;
        taken.position[1] = position_b;
        taken.position[2] = position_c;
        taken.position[3] = position_d;
        expected_results.push_back(step_sequencer(taken));
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ bench/tb_multiplexed_servo_pulse_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiplexed_servo_pulse_sequencer_core
// Drives ticks and position loads into the servo sequencer under a range of
// min_pulse and slot_length settings, with random gaps and back-pressure,
// and leaves the checking of every result to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_multiplexed_servo_pulse_sequencer_core;

  localparam logic [msps_pkg::ADDR_W-1:0] MIN_PULSE_ADDR   =
    {msps_pkg::REG_MIN_PULSE, 2'b00};
  localparam logic [msps_pkg::ADDR_W-1:0] SLOT_LENGTH_ADDR =
    {msps_pkg::REG_SLOT_LENGTH, 2'b00};
  localparam int MAX_WAIT       = 17;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic                          command    = msps_pkg::CMD_TICK;
  logic [msps_pkg::POS_W-1:0]    position_a = '0;
  logic [msps_pkg::POS_W-1:0]    position_b = '0;
  logic [msps_pkg::POS_W-1:0]    position_c = '0;
  logic [msps_pkg::POS_W-1:0]    position_d = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [msps_pkg::NUM_PINS-1:0] pin_levels;
  logic [msps_pkg::CHAN_W-1:0]   slot_channel;
  logic                          slot_end;
  logic                          psel       = 1'b0;
  logic                          penable    = 1'b0;
  logic                          pwrite     = 1'b0;
  logic [msps_pkg::ADDR_W-1:0]   paddr      = '0;
  logic [msps_pkg::DATA_W-1:0]   pwdata     = '0;
  logic [msps_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  int pending;
  int failures;
  int quiet_cycles = 0;
  bit sender_calm   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multiplexed_servo_pulse_sequencer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .position_a   (position_a),
    .position_b   (position_b),
    .position_c   (position_c),
    .position_d   (position_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pin_levels   (pin_levels),
    .slot_channel (slot_channel),
    .slot_end     (slot_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  msps_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .position_a   (position_a),
    .position_b   (position_b),
    .position_c   (position_c),
    .position_d   (position_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pin_levels   (pin_levels),
    .slot_channel (slot_channel),
    .slot_end     (slot_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pending      (pending),
    .failures     (failures)
  );

  // Waits until every result has been taken, then lets the pipe settle.
  task automatic drain_results();
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // A setup phase and an access phase, then the bus goes idle so that a following
  // write starts from a clean bus.
  task automatic write_reg(input logic [msps_pkg::ADDR_W-1:0] addr,
                           input logic [msps_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // The last item stays on the bus after it is taken, so valid is dropped
  // before the block is drained and written.
  task automatic configure(input logic [msps_pkg::TIME_W-1:0] min_pulse,
                           input logic [msps_pkg::TIME_W-1:0] slot_length);
    in_valid <= 1'b0;
    drain_results();
    write_reg(MIN_PULSE_ADDR, msps_pkg::DATA_W'(min_pulse));
    write_reg(SLOT_LENGTH_ADDR, msps_pkg::DATA_W'(slot_length));
  endtask

  task automatic send_item(input logic cmd, input logic [msps_pkg::POS_W-1:0] a,
                           input logic [msps_pkg::POS_W-1:0] b,
                           input logic [msps_pkg::POS_W-1:0] c,
                           input logic [msps_pkg::POS_W-1:0] d);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    position_a <= a;
    position_b <= b;
    position_c <= c;
    position_d <= d;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
  endtask

  // Mostly ticks; loads carry small positions so that on times vary within
  // short slots, with the odd full-range value thrown in.
  task automatic send_random(input int count, input int pos_max);
    logic                       cmd;
    logic [msps_pkg::POS_W-1:0] pos [msps_pkg::NUM_PINS];
    for (int k = 0; k < count; k++) begin
      cmd = ($urandom_range(0, 6) == 0) ? msps_pkg::CMD_LOAD : msps_pkg::CMD_TICK;
      for (int i = 0; i < msps_pkg::NUM_PINS; i++) begin
        pos[i] = ($urandom_range(0, 3) == 0) ?
                 msps_pkg::POS_W'($urandom_range(0, 255)) :
                 msps_pkg::POS_W'($urandom_range(0, pos_max));
      end
      send_item(cmd, pos[0], pos[1], pos[2], pos[3]);
    end
  endtask

  task automatic send_ticks(input int count);
    for (int k = 0; k < count; k++) begin
      send_item(msps_pkg::CMD_TICK, msps_pkg::POS_W'($urandom),
                msps_pkg::POS_W'($urandom), msps_pkg::POS_W'($urandom),
                msps_pkg::POS_W'($urandom));
    end
  endtask

  // Receiver: a random stall before each result, calm stretches, and one long
  // hold-off so that the block fills up and stalls its input.
  initial begin
    int  wait_cycles;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if ($urandom_range(0, 39) == 0) calm = !calm;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("multiplexed_servo_pulse_sequencer_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Short slots: zero on time, capped on time with no rest, loads mid-slot.
    configure(16'd0, 16'd4);
    send_item(msps_pkg::CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_ticks(5);
    send_item(msps_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
    send_ticks(5);
    send_item(msps_pkg::CMD_LOAD, 8'hA5, 8'h5A, 8'h0F, 8'hF0);
    send_item(msps_pkg::CMD_LOAD, 8'h01, 8'h02, 8'h03, 8'h04);
    send_ticks(6);
    // A slot length of zero still gives one tick high and one tick of rest.
    configure(16'd0, 16'd0);
    send_ticks(4);

    configure(16'd3, 16'd24);
    send_random(200, 31);
    configure(16'd0, 16'd8);
    send_random(150, 15);
    configure(16'hFFFF, 16'd12);
    send_random(120, 255);
    configure(16'd5, 16'd0);
    send_random(100, 255);
    repeat (3) begin
      configure(msps_pkg::TIME_W'($urandom_range(0, 12)),
                msps_pkg::TIME_W'($urandom_range(0, 40)));
      send_random(150, 31);
    end
    // Long slots last, as they leave the counters far from a slot boundary.
    configure(16'd0, 16'hFFFF);
    send_random(40, 255);
    configure(msps_pkg::MIN_PULSE_RST, msps_pkg::SLOT_LENGTH_RST);
    send_random(40, 255);
    configure(16'hFFFF, 16'hFFFF);
    send_random(40, 255);
    in_valid <= 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("multiplexed_servo_pulse_sequencer_core test passed");
    end else begin
      $display("multiplexed_servo_pulse_sequencer_core test failed");
    end
    $finish;
  end

endmodule
